// ===== hdl/jtl_pkg.sv =====
`default_nettype none
package jtl_pkg;

   // result kinds
   localparam logic [1:0] KIND_TEXT = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;
   localparam logic [1:0] KIND_END  = 2'd3;

   // token types
   localparam logic [3:0] TOK_NULL    = 4'd0;
   localparam logic [3:0] TOK_BOOL    = 4'd1;
   localparam logic [3:0] TOK_INTEGER = 4'd2;
   localparam logic [3:0] TOK_NUMBER  = 4'd3;
   localparam logic [3:0] TOK_STRING  = 4'd4;
   localparam logic [3:0] TOK_LBRACK  = 4'd5;
   localparam logic [3:0] TOK_RBRACK  = 4'd6;
   localparam logic [3:0] TOK_COMMA   = 4'd7;
   localparam logic [3:0] TOK_COLON   = 4'd8;
   localparam logic [3:0] TOK_LBRACE  = 4'd9;
   localparam logic [3:0] TOK_RBRACE  = 4'd10;

   // keyword selectors
   localparam logic [1:0] KW_TRUE  = 2'd0;
   localparam logic [1:0] KW_FALSE = 2'd1;
   localparam logic [1:0] KW_NULL  = 2'd2;

   // characters of interest
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COMMA  = 8'h2c;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3a;
   localparam logic [7:0] CH_LBRACK = 8'h5b;
   localparam logic [7:0] CH_RBRACK = 8'h5d;
   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6e;

   // scan modes, one-hot
   typedef enum logic [6:0] {
      MODE_IDLE    = 7'b0000001,
      MODE_SLASH   = 7'b0000010,
      MODE_COMMENT = 7'b0000100,
      MODE_STRING  = 7'b0001000,
      MODE_NUMBER  = 7'b0010000,
      MODE_KEYWORD = 7'b0100000,
      MODE_ERROR   = 7'b1000000
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic       dot_seen;
      logic [1:0] kw_choice;
      logic [2:0] kw_pos;
   } scan_state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] token_type;
      logic [7:0] text_byte;
   } result_type;

   localparam scan_state_type STATE_RESET = '{
      mode: MODE_IDLE, dot_seen: 1'b0, kw_choice: KW_TRUE, kw_pos: 3'd0
   };

   // keyword letters by selector and position
   function automatic logic [7:0] kw_char(input logic [1:0] choice, input logic [2:0] pos);
      logic [7:0] c;
      c = 8'h00;
      case (choice)
         KW_TRUE: begin
            case (pos)
               3'd0: c = 8'h74;
               3'd1: c = 8'h72;
               3'd2: c = 8'h75;
               3'd3: c = 8'h65;
               default: c = 8'h00;
            endcase
         end
         KW_FALSE: begin
            case (pos)
               3'd0: c = 8'h66;
               3'd1: c = 8'h61;
               3'd2: c = 8'h6c;
               3'd3: c = 8'h73;
               3'd4: c = 8'h65;
               default: c = 8'h00;
            endcase
         end
         KW_NULL: begin
            case (pos)
               3'd0: c = 8'h6e;
               3'd1: c = 8'h75;
               3'd2: c = 8'h6c;
               3'd3: c = 8'h6c;
               default: c = 8'h00;
            endcase
         end
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] kw_len(input logic [1:0] choice);
      logic [2:0] l;
      case (choice)
         KW_TRUE:  l = 3'd4;
         KW_FALSE: l = 3'd5;
         KW_NULL:  l = 3'd4;
         default:  l = 3'd0;
      endcase
      return l;
   endfunction

   function automatic logic [3:0] kw_type(input logic [1:0] choice);
      logic [3:0] t;
      case (choice)
         KW_TRUE:  t = TOK_BOOL;
         KW_FALSE: t = TOK_BOOL;
         default:  t = TOK_NULL;
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/jtl_lexer.sv =====
`default_nettype none
// Next-state and result decode for one document byte or end mark.
module jtl_lexer (
   input  wire jtl_pkg::scan_state_type state,
   input  wire logic [7:0]              data_byte,
   input  wire logic                    end_of_data,
   output jtl_pkg::scan_state_type      state_next,
   output logic [1:0]                   res_count,
   output jtl_pkg::result_type          res0,
   output jtl_pkg::result_type          res1
);

   // outcome of a byte seen between tokens
   jtl_pkg::scan_state_type idle_state;
   logic                    idle_has;
   jtl_pkg::result_type     idle_res;

   logic       is_digit;
   logic       is_num_byte;
   logic [3:0] num_type;
   logic [3:0] num_type_upd;
   logic [2:0] kw_pos_inc;

   assign is_digit     = (data_byte >= jtl_pkg::CH_ZERO) && (data_byte <= jtl_pkg::CH_NINE);
   assign is_num_byte  = is_digit || (data_byte == jtl_pkg::CH_MINUS) ||
                         (data_byte == jtl_pkg::CH_DOT);
   assign num_type     = state.dot_seen ? jtl_pkg::TOK_NUMBER : jtl_pkg::TOK_INTEGER;
   assign num_type_upd = (state.dot_seen || (data_byte == jtl_pkg::CH_DOT)) ?
                         jtl_pkg::TOK_NUMBER : jtl_pkg::TOK_INTEGER;
   assign kw_pos_inc   = state.kw_pos + 3'd1;

   // between-token byte classification
   always_comb begin
      idle_state      = state;
      idle_state.mode = jtl_pkg::MODE_IDLE;
      idle_has        = 1'b1;
      idle_res        = '{kind: jtl_pkg::KIND_DONE, token_type: 4'd0, text_byte: 8'd0};
      case (data_byte)
         jtl_pkg::CH_SPACE, jtl_pkg::CH_TAB, jtl_pkg::CH_LF, jtl_pkg::CH_CR: begin
            idle_has = 1'b0;
         end
         jtl_pkg::CH_SLASH: begin
            idle_has        = 1'b0;
            idle_state.mode = jtl_pkg::MODE_SLASH;
         end
         jtl_pkg::CH_QUOTE: begin
            idle_has        = 1'b0;
            idle_state.mode = jtl_pkg::MODE_STRING;
         end
         jtl_pkg::CH_LBRACK: idle_res.token_type = jtl_pkg::TOK_LBRACK;
         jtl_pkg::CH_RBRACK: idle_res.token_type = jtl_pkg::TOK_RBRACK;
         jtl_pkg::CH_COMMA:  idle_res.token_type = jtl_pkg::TOK_COMMA;
         jtl_pkg::CH_COLON:  idle_res.token_type = jtl_pkg::TOK_COLON;
         jtl_pkg::CH_LBRACE: idle_res.token_type = jtl_pkg::TOK_LBRACE;
         jtl_pkg::CH_RBRACE: idle_res.token_type = jtl_pkg::TOK_RBRACE;
         jtl_pkg::CH_T, jtl_pkg::CH_F, jtl_pkg::CH_N: begin
            idle_state.mode = jtl_pkg::MODE_KEYWORD;
            idle_state.kw_pos = 3'd1;
            if (data_byte == jtl_pkg::CH_T) begin
               idle_state.kw_choice = jtl_pkg::KW_TRUE;
            end else if (data_byte == jtl_pkg::CH_F) begin
               idle_state.kw_choice = jtl_pkg::KW_FALSE;
            end else begin
               idle_state.kw_choice = jtl_pkg::KW_NULL;
            end
            idle_res.kind       = jtl_pkg::KIND_TEXT;
            idle_res.token_type = jtl_pkg::kw_type(idle_state.kw_choice);
            idle_res.text_byte  = data_byte;
         end
         default: begin
            if (is_digit || (data_byte == jtl_pkg::CH_MINUS)) begin
               idle_state.mode     = jtl_pkg::MODE_NUMBER;
               idle_state.dot_seen = 1'b0;
               idle_res.kind       = jtl_pkg::KIND_TEXT;
               idle_res.token_type = jtl_pkg::TOK_INTEGER;
               idle_res.text_byte  = data_byte;
            end else begin
               idle_state.mode = jtl_pkg::MODE_ERROR;
               idle_res.kind   = jtl_pkg::KIND_ERR;
            end
         end
      endcase
   end

   // main decode by scan mode
   always_comb begin
      state_next = state;
      res_count  = 2'd0;
      res0       = '{kind: jtl_pkg::KIND_ERR, token_type: 4'd0, text_byte: 8'd0};
      res1       = '{kind: jtl_pkg::KIND_END, token_type: 4'd0, text_byte: 8'd0};
      if (end_of_data) begin
         state_next = jtl_pkg::STATE_RESET;
         if (state.mode == jtl_pkg::MODE_NUMBER) begin
            res_count       = 2'd2;
            res0.kind       = jtl_pkg::KIND_DONE;
            res0.token_type = num_type;
         end else if (state.mode == jtl_pkg::MODE_SLASH ||
                      state.mode == jtl_pkg::MODE_COMMENT ||
                      state.mode == jtl_pkg::MODE_STRING ||
                      state.mode == jtl_pkg::MODE_KEYWORD) begin
            res_count = 2'd2;
         end else begin
            res_count = 2'd1;
            res0.kind = jtl_pkg::KIND_END;
         end
      end else begin
         case (state.mode)
            jtl_pkg::MODE_IDLE: begin
               state_next = idle_state;
               res_count  = {1'b0, idle_has};
               res0       = idle_res;
            end
            jtl_pkg::MODE_SLASH: begin
               if (data_byte == jtl_pkg::CH_SLASH) begin
                  state_next.mode = jtl_pkg::MODE_COMMENT;
               end else begin
                  state_next.mode = jtl_pkg::MODE_ERROR;
                  res_count       = 2'd1;
               end
            end
            jtl_pkg::MODE_COMMENT: begin
               if (data_byte == jtl_pkg::CH_LF || data_byte == jtl_pkg::CH_CR) begin
                  state_next.mode = jtl_pkg::MODE_IDLE;
               end else if (data_byte == jtl_pkg::CH_NUL) begin
                  state_next.mode = jtl_pkg::MODE_ERROR;
                  res_count       = 2'd1;
               end
            end
            jtl_pkg::MODE_STRING: begin
               if (data_byte == jtl_pkg::CH_QUOTE) begin
                  state_next.mode = jtl_pkg::MODE_IDLE;
                  res_count       = 2'd1;
                  res0.kind       = jtl_pkg::KIND_DONE;
                  res0.token_type = jtl_pkg::TOK_STRING;
               end else if (data_byte == jtl_pkg::CH_NUL) begin
                  state_next.mode = jtl_pkg::MODE_ERROR;
                  res_count       = 2'd1;
               end else begin
                  res_count       = 2'd1;
                  res0.kind       = jtl_pkg::KIND_TEXT;
                  res0.token_type = jtl_pkg::TOK_STRING;
                  res0.text_byte  = data_byte;
               end
            end
            jtl_pkg::MODE_NUMBER: begin
               if (is_num_byte) begin
                  state_next.dot_seen = state.dot_seen || (data_byte == jtl_pkg::CH_DOT);
                  res_count           = 2'd1;
                  res0.kind           = jtl_pkg::KIND_TEXT;
                  res0.token_type     = num_type_upd;
                  res0.text_byte      = data_byte;
               end else if (data_byte == jtl_pkg::CH_NUL) begin
                  state_next.mode = jtl_pkg::MODE_ERROR;
                  res_count       = 2'd1;
               end else begin
                  // number ends, terminating byte is handled as a fresh byte
                  state_next      = idle_state;
                  res_count       = idle_has ? 2'd2 : 2'd1;
                  res0.kind       = jtl_pkg::KIND_DONE;
                  res0.token_type = num_type;
                  res1            = idle_res;
               end
            end
            jtl_pkg::MODE_KEYWORD: begin
               if ((state.kw_pos < jtl_pkg::kw_len(state.kw_choice)) &&
                   (data_byte == jtl_pkg::kw_char(state.kw_choice, state.kw_pos))) begin
                  state_next.kw_pos = kw_pos_inc;
                  res0.kind         = jtl_pkg::KIND_TEXT;
                  res0.token_type   = jtl_pkg::kw_type(state.kw_choice);
                  res0.text_byte    = data_byte;
                  res1.kind         = jtl_pkg::KIND_DONE;
                  res1.token_type   = jtl_pkg::kw_type(state.kw_choice);
                  if (kw_pos_inc == jtl_pkg::kw_len(state.kw_choice)) begin
                     state_next.mode = jtl_pkg::MODE_IDLE;
                     res_count       = 2'd2;
                  end else begin
                     res_count = 2'd1;
                  end
               end else begin
                  state_next.mode = jtl_pkg::MODE_ERROR;
                  res_count       = 2'd1;
               end
            end
            default: begin
               // error mode: bytes are swallowed until the end mark
               res_count = 2'd0;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== hdl/json_token_lexer.sv =====
`default_nettype none
// JSON token lexer.
// req channel: one document byte per transaction in req_tdata, or the end of
// the document when req_tlast is high (req_tdata is then ignored).
// rsp channel: token text bytes, token completions, errors and the document
// end; rsp_tuser gives the result kind, rsp_tlast marks the final result
// caused by one request transaction.
// A byte taken on req sits in the input register; its first result is loaded
// into the result register once the result buffer can take it, and is offered
// on rsp from there.
// Throughput: one request per cycle while rsp_tready is high, for bytes that
// cause zero or one result; a byte that causes two results (number or keyword
// end, end mark after an open token) holds the input register while the second
// result leaves from the two-entry result buffer.
// Reset returns the scanner to the idle state between tokens and empties
// both registers. When rsp_tready is low, results hold in the buffer and the
// input register fills; req_tready then drops until results drain.
module json_token_lexer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // end_of_data
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [3:0] token_type, [11:4] text_byte, [15:12] zero
   output logic [1:0]       rsp_tuser,   // [1:0] result_kind
   output logic             rsp_tlast    // last_of_run
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff,  in_byte_in;
   logic       in_end_ff,   in_end_in;

   // scanner state
   jtl_pkg::scan_state_type state_ff, state_in, state_next;

   // result buffer: slot 0 is presented, slot 1 waits behind it
   logic [1:0]          cnt_ff, cnt_in;
   jtl_pkg::result_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic                last0_ff, last0_in;

   logic [1:0]          res_count;
   jtl_pkg::result_type res0, res1;
   logic                pop;
   logic [1:0]          cnt_after_pop;
   logic                in_move;

   jtl_lexer u_lexer (
      .state       (state_ff),
      .data_byte   (in_byte_ff),
      .end_of_data (in_end_ff),
      .state_next  (state_next),
      .res_count   (res_count),
      .res0        (res0),
      .res1        (res1)
   );

   // handshake control
   assign pop           = rsp_tvalid && rsp_tready;
   assign cnt_after_pop = cnt_ff - {1'b0, pop};
   assign in_move       = in_valid_ff && ((res_count == 2'd0) || (cnt_after_pop == 2'd0));
   assign req_tready    = !in_valid_ff || in_move;

   // input register next value
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_end_in   = req_tlast;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end
   end

   // scanner state and result buffer next value
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_after_pop;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      last0_in = last0_ff;
      if (pop && cnt_ff == 2'd2) begin
         slot0_in = slot1_ff;
         last0_in = 1'b1;
      end
      if (in_move) begin
         state_in = state_next;
         if (res_count != 2'd0) begin
            cnt_in   = res_count;
            slot0_in = res0;
            slot1_in = res1;
            last0_in = (res_count == 2'd1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= jtl_pkg::STATE_RESET;
         cnt_ff      <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_end_ff  <= in_end_in;
      slot0_ff   <= slot0_in;
      slot1_ff   <= slot1_in;
      last0_ff   <= last0_in;
   end

   // result outputs
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {4'd0, slot0_ff.text_byte, slot0_ff.token_type};
   assign rsp_tuser  = slot0_ff.kind;
   assign rsp_tlast  = last0_ff;

endmodule
`default_nettype wire

// ===== bench/jtl_checker.sv =====
`timescale 1ns / 100ps
// Lexer scoreboard: follows every request transaction with its own scanner,
// queues the results it predicts and compares each response transaction
// against the oldest one still due.
module jtl_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_data
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [3:0] token_type, [11:4] text_byte, [15:12] zero
   input  logic [1:0]  rsp_tuser,   // [1:0] result_kind
   input  logic        rsp_tlast,   // last_of_run
   output int          fail_count,
   output int          pending,
   output int          text_count,
   output int          done_count,
   output int          error_count,
   output int          end_count
);

   localparam logic [3:0] NO_TYPE = 4'd0;
   localparam logic [7:0] NO_TEXT = 8'h00;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] tok;
      logic [7:0] text;
      logic       last;
   } lex_result_type;

   lex_result_type results_due[$];
   lex_result_type step_out[$];

   // scanner state
   jtl_pkg::mode_type scan_mode = jtl_pkg::MODE_IDLE;
   logic              dot_seen  = 1'b0;
   logic [1:0]        kw_choice = jtl_pkg::KW_TRUE;
   logic [2:0]        kw_pos    = 3'd0;

   function automatic void clear_scan();
      scan_mode = jtl_pkg::MODE_IDLE;
      dot_seen  = 1'b0;
      kw_choice = jtl_pkg::KW_TRUE;
      kw_pos    = 3'd0;
   endfunction

   function automatic void put(input logic [1:0] kind, input logic [3:0] tok,
                               input logic [7:0] text);
      lex_result_type r;
      r.kind = kind;
      r.tok  = tok;
      r.text = text;
      r.last = 1'b0;
      step_out.push_back(r);
   endfunction

   function automatic void to_error();
      scan_mode = jtl_pkg::MODE_ERROR;
      put(jtl_pkg::KIND_ERR, NO_TYPE, NO_TEXT);
   endfunction

   function automatic logic [3:0] number_type();
      return dot_seen ? jtl_pkg::TOK_NUMBER : jtl_pkg::TOK_INTEGER;
   endfunction

   function automatic logic [3:0] word_type(input logic [1:0] choice);
      return (choice == jtl_pkg::KW_NULL) ? jtl_pkg::TOK_NULL : jtl_pkg::TOK_BOOL;
   endfunction

   function automatic logic [2:0] word_len(input logic [1:0] choice);
      return (choice == jtl_pkg::KW_FALSE) ? 3'd5 : 3'd4;
   endfunction

   // keyword spelled left-aligned in five byte slots
   function automatic logic [7:0] word_letter(input logic [1:0] choice,
                                              input logic [2:0] pos);
      logic [39:0] spell;
      case (choice)
         jtl_pkg::KW_TRUE:  spell = {"true", 8'h00};
         jtl_pkg::KW_FALSE: spell = "false";
         default:           spell = {"null", 8'h00};
      endcase
      return spell[39 - 8 * int'(pos) -: 8];
   endfunction

   function automatic void open_word(input logic [1:0] choice, input logic [7:0] b);
      scan_mode = jtl_pkg::MODE_KEYWORD;
      kw_choice = choice;
      kw_pos    = 3'd1;
      put(jtl_pkg::KIND_TEXT, word_type(choice), b);
   endfunction

   // byte seen between tokens
   function automatic void idle_byte(input logic [7:0] b);
      case (b)
         jtl_pkg::CH_SPACE, jtl_pkg::CH_TAB, jtl_pkg::CH_LF, jtl_pkg::CH_CR: begin
         end
         jtl_pkg::CH_SLASH:  scan_mode = jtl_pkg::MODE_SLASH;
         jtl_pkg::CH_QUOTE:  scan_mode = jtl_pkg::MODE_STRING;
         jtl_pkg::CH_LBRACK: put(jtl_pkg::KIND_DONE, jtl_pkg::TOK_LBRACK, NO_TEXT);
         jtl_pkg::CH_RBRACK: put(jtl_pkg::KIND_DONE, jtl_pkg::TOK_RBRACK, NO_TEXT);
         jtl_pkg::CH_COMMA:  put(jtl_pkg::KIND_DONE, jtl_pkg::TOK_COMMA, NO_TEXT);
         jtl_pkg::CH_COLON:  put(jtl_pkg::KIND_DONE, jtl_pkg::TOK_COLON, NO_TEXT);
         jtl_pkg::CH_LBRACE: put(jtl_pkg::KIND_DONE, jtl_pkg::TOK_LBRACE, NO_TEXT);
         jtl_pkg::CH_RBRACE: put(jtl_pkg::KIND_DONE, jtl_pkg::TOK_RBRACE, NO_TEXT);
         jtl_pkg::CH_T:      open_word(jtl_pkg::KW_TRUE, b);
         jtl_pkg::CH_F:      open_word(jtl_pkg::KW_FALSE, b);
         jtl_pkg::CH_N:      open_word(jtl_pkg::KW_NULL, b);
         default: begin
            if (b == jtl_pkg::CH_MINUS ||
                (b >= jtl_pkg::CH_ZERO && b <= jtl_pkg::CH_NINE)) begin
               scan_mode = jtl_pkg::MODE_NUMBER;
               dot_seen  = 1'b0;
               put(jtl_pkg::KIND_TEXT, jtl_pkg::TOK_INTEGER, b);
            end else begin
               to_error();
            end
         end
      endcase
   endfunction

   // one request transaction: update the scanner, queue what it produces
   function automatic void lex_step(input logic [7:0] b, input logic eod);
      lex_result_type r;
      step_out.delete();
      if (eod) begin
         if (scan_mode == jtl_pkg::MODE_NUMBER)
            put(jtl_pkg::KIND_DONE, number_type(), NO_TEXT);
         else if (scan_mode != jtl_pkg::MODE_IDLE && scan_mode != jtl_pkg::MODE_ERROR)
            put(jtl_pkg::KIND_ERR, NO_TYPE, NO_TEXT);
         put(jtl_pkg::KIND_END, NO_TYPE, NO_TEXT);
         clear_scan();
      end else begin
         case (scan_mode)
            jtl_pkg::MODE_IDLE: idle_byte(b);
            jtl_pkg::MODE_SLASH: begin
               if (b == jtl_pkg::CH_SLASH) scan_mode = jtl_pkg::MODE_COMMENT;
               else to_error();
            end
            jtl_pkg::MODE_COMMENT: begin
               if (b == jtl_pkg::CH_LF || b == jtl_pkg::CH_CR) scan_mode = jtl_pkg::MODE_IDLE;
               else if (b == jtl_pkg::CH_NUL) to_error();
            end
            jtl_pkg::MODE_STRING: begin
               if (b == jtl_pkg::CH_QUOTE) begin
                  scan_mode = jtl_pkg::MODE_IDLE;
                  put(jtl_pkg::KIND_DONE, jtl_pkg::TOK_STRING, NO_TEXT);
               end else if (b == jtl_pkg::CH_NUL) begin
                  to_error();
               end else begin
                  put(jtl_pkg::KIND_TEXT, jtl_pkg::TOK_STRING, b);
               end
            end
            jtl_pkg::MODE_NUMBER: begin
               if ((b >= jtl_pkg::CH_ZERO && b <= jtl_pkg::CH_NINE) ||
                   b == jtl_pkg::CH_MINUS || b == jtl_pkg::CH_DOT) begin
                  if (b == jtl_pkg::CH_DOT) dot_seen = 1'b1;
                  put(jtl_pkg::KIND_TEXT, number_type(), b);
               end else if (b == jtl_pkg::CH_NUL) begin
                  to_error();
               end else begin
                  // number ends; the terminating byte is lexed on its own
                  put(jtl_pkg::KIND_DONE, number_type(), NO_TEXT);
                  scan_mode = jtl_pkg::MODE_IDLE;
                  idle_byte(b);
               end
            end
            jtl_pkg::MODE_KEYWORD: begin
               if (kw_pos < word_len(kw_choice) &&
                   b == word_letter(kw_choice, kw_pos)) begin
                  put(jtl_pkg::KIND_TEXT, word_type(kw_choice), b);
                  kw_pos = kw_pos + 3'd1;
                  if (kw_pos == word_len(kw_choice)) begin
                     put(jtl_pkg::KIND_DONE, word_type(kw_choice), NO_TEXT);
                     scan_mode = jtl_pkg::MODE_IDLE;
                  end
               end else begin
                  to_error();
               end
            end
            default: begin
            end
         endcase
      end
      foreach (step_out[i]) begin
         r = step_out[i];
         r.last = (i == step_out.size() - 1);
         results_due.push_back(r);
      end
   endfunction

   // compare responses first (they belong to older requests), then predict
   always @(posedge clock) begin : watch
      lex_result_type want;
      logic [15:0]    want_data;
      if (reset) begin
         clear_scan();
         results_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            case (rsp_tuser)
               jtl_pkg::KIND_TEXT: text_count++;
               jtl_pkg::KIND_DONE: done_count++;
               jtl_pkg::KIND_ERR:  error_count++;
               default:            end_count++;
            endcase
            if (results_due.size() == 0) begin
               $display("%0t: unexpected result: expected none, got kind %0d tdata %h last %b",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               want = results_due.pop_front();
               want_data = {4'h0, want.text, want.tok};
               if (rsp_tuser !== want.kind || rsp_tdata !== want_data ||
                   rsp_tlast !== want.last) begin
                  $display("%0t: result mismatch: expected kind %0d type %0d text %h last %b",
                           $time, want.kind, want.tok, want.text, want.last,
                           " pad 0, got kind %0d type %0d text %h last %b pad %h",
                           rsp_tuser, rsp_tdata[3:0], rsp_tdata[11:4], rsp_tlast,
                           rsp_tdata[15:12]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            lex_step(req_tdata, req_tlast);
      end
      pending = results_due.size();
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
module tb;

   localparam int HOLD_CYCLES = 300;

   // token shapes for the document generator
   localparam int G_SYMBOL  = 0;
   localparam int G_STRING  = 1;
   localparam int G_NUMBER  = 2;
   localparam int G_WORD    = 3;
   localparam int G_SPACE   = 4;
   localparam int G_COMMENT = 5;
   localparam int G_NOISE   = 6;
   localparam int G_SLASH   = 7;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        req_tlast  = 1'b0;    // end_of_data
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [3:0] token_type, [11:4] text_byte, [15:12] zero
   logic [1:0]  rsp_tuser;            // [1:0] result_kind
   logic        rsp_tlast;            // last_of_run

   int fail_count, pending, text_count, done_count, error_count, end_count;
   int send_idle_pct = 26;
   int recv_idle_pct = 73;
   int hold_asked    = 0;
   int items_sent    = 0;
   int docs_sent     = 0;
   logic [7:0] doc_bytes[$];

   json_token_lexer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   jtl_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .pending     (pending),
      .text_count  (text_count),
      .done_count  (done_count),
      .error_count (error_count),
      .end_count   (end_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // response side: random back-pressure, plus a long hold when asked
   initial begin : receiver
      int hold_taken;
      int hold_left;
      hold_taken = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // appends one token (or a cut-off one) to the document being built
   function automatic void add_token(input bit unfinished);
      int shape;
      int n;
      int r;
      logic [7:0] b;
      string w;
      if (unfinished) begin
         case ($urandom_range(3))
            0:       shape = G_STRING;
            1:       shape = G_WORD;
            2:       shape = G_COMMENT;
            default: shape = G_SLASH;
         endcase
      end else begin
         r = $urandom_range(99);
         shape = (r < 22) ? G_SYMBOL : (r < 37) ? G_STRING : (r < 57) ? G_NUMBER :
                 (r < 72) ? G_WORD : (r < 86) ? G_SPACE : (r < 94) ? G_COMMENT :
                 (r < 98) ? G_NOISE : G_SLASH;
      end
      case (shape)
         G_SYMBOL: begin
            case ($urandom_range(5))
               0:       doc_bytes.push_back(jtl_pkg::CH_LBRACK);
               1:       doc_bytes.push_back(jtl_pkg::CH_RBRACK);
               2:       doc_bytes.push_back(jtl_pkg::CH_LBRACE);
               3:       doc_bytes.push_back(jtl_pkg::CH_RBRACE);
               4:       doc_bytes.push_back(jtl_pkg::CH_COMMA);
               default: doc_bytes.push_back(jtl_pkg::CH_COLON);
            endcase
         end
         G_STRING: begin
            doc_bytes.push_back(jtl_pkg::CH_QUOTE);
            n = $urandom_range(6);
            repeat (n) begin
               do b = 8'($urandom_range(1, 255)); while (b == jtl_pkg::CH_QUOTE);
               if ($urandom_range(49) == 0) b = jtl_pkg::CH_NUL;
               doc_bytes.push_back(b);
            end
            if (!unfinished) doc_bytes.push_back(jtl_pkg::CH_QUOTE);
         end
         G_NUMBER: begin
            doc_bytes.push_back(($urandom_range(3) == 0) ? jtl_pkg::CH_MINUS :
                                jtl_pkg::CH_ZERO + 8'($urandom_range(9)));
            n = $urandom_range(5);
            repeat (n) begin
               r = $urandom_range(9);
               b = (r == 0) ? jtl_pkg::CH_DOT : (r == 1) ? jtl_pkg::CH_MINUS :
                   jtl_pkg::CH_ZERO + 8'($urandom_range(9));
               doc_bytes.push_back(b);
            end
            if ($urandom_range(49) == 0) doc_bytes.push_back(jtl_pkg::CH_NUL);
         end
         G_WORD: begin
            case ($urandom_range(2))
               0:       w = "true";
               1:       w = "false";
               default: w = "null";
            endcase
            n = unfinished ? $urandom_range(1, w.len() - 1) : w.len();
            for (int i = 0; i < n; i++) begin
               b = w[i];
               // occasional misspelling
               if (!unfinished && i > 0 && $urandom_range(39) == 0) b = 8'($urandom_range(255));
               doc_bytes.push_back(b);
            end
         end
         G_SPACE: begin
            n = $urandom_range(1, 3);
            repeat (n) begin
               case ($urandom_range(3))
                  0:       doc_bytes.push_back(jtl_pkg::CH_SPACE);
                  1:       doc_bytes.push_back(jtl_pkg::CH_TAB);
                  2:       doc_bytes.push_back(jtl_pkg::CH_LF);
                  default: doc_bytes.push_back(jtl_pkg::CH_CR);
               endcase
            end
         end
         G_COMMENT: begin
            doc_bytes.push_back(jtl_pkg::CH_SLASH);
            doc_bytes.push_back(jtl_pkg::CH_SLASH);
            n = $urandom_range(5);
            repeat (n) begin
               do b = 8'($urandom_range(1, 255));
               while (b == jtl_pkg::CH_LF || b == jtl_pkg::CH_CR);
               if ($urandom_range(39) == 0) b = jtl_pkg::CH_NUL;
               doc_bytes.push_back(b);
            end
            if (!unfinished)
               doc_bytes.push_back($urandom_range(1) ? jtl_pkg::CH_LF : jtl_pkg::CH_CR);
         end
         G_NOISE: begin
            if ($urandom_range(1)) doc_bytes.push_back(8'($urandom_range(255)));
            else doc_bytes.push_back($urandom_range(1) ? jtl_pkg::CH_DOT : jtl_pkg::CH_NUL);
         end
         default: begin
            doc_bytes.push_back(jtl_pkg::CH_SLASH);
            if (!unfinished) doc_bytes.push_back(8'($urandom_range(255)));
         end
      endcase
   endfunction

   // one request transaction; called at a rising edge, returns at its handshake
   task automatic send_item(input logic [7:0] b, input logic eod);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eod;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // sends doc_bytes (built here unless given) and the closing end mark
   task automatic send_doc(input bit directed);
      int n;
      if (!directed) begin
         doc_bytes.delete();
         n = $urandom_range(1, 14);
         repeat (n) add_token(1'b0);
         if ($urandom_range(9) == 0) add_token(1'b1);
      end
      foreach (doc_bytes[i]) send_item(doc_bytes[i], 1'b0);
      send_item(8'($urandom_range(255)), 1'b1);
      docs_sent++;
   endtask

   // sender stops until every predicted result is out; returns at a falling edge
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // symbols, a string with a high byte, a number closed by a bracket
      doc_bytes = '{jtl_pkg::CH_LBRACE, jtl_pkg::CH_QUOTE, 8'hff, jtl_pkg::CH_QUOTE,
                    jtl_pkg::CH_COLON, jtl_pkg::CH_MINUS, jtl_pkg::CH_DOT,
                    jtl_pkg::CH_RBRACK, jtl_pkg::CH_COMMA, jtl_pkg::CH_RBRACE};
      send_doc(1'b1);
      // keyword, whitespace, comment, number still open at the end mark
      doc_bytes = '{jtl_pkg::CH_TAB, jtl_pkg::CH_N, "u", "l", "l", jtl_pkg::CH_LF,
                    jtl_pkg::CH_SLASH, jtl_pkg::CH_SLASH, jtl_pkg::CH_CR, "7"};
      send_doc(1'b1);
      // bad bytes between tokens: lone dot, then NUL
      doc_bytes = '{jtl_pkg::CH_DOT};
      send_doc(1'b1);
      doc_bytes = '{jtl_pkg::CH_NUL};
      send_doc(1'b1);

      // slow receiver
      while (items_sent < 450) send_doc(1'b0);
      wait_drained();

      // slow sender
      send_idle_pct = 73;
      recv_idle_pct = 26;
      @(posedge clock);
      while (items_sent < 880) send_doc(1'b0);
      wait_drained();

      // full rate, opening with a long response hold
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_asked++;
      @(posedge clock);
      while (items_sent < 1130) send_doc(1'b0);
      wait_drained();

      repeat (10) @(negedge clock);
      $display("Lexed %0d documents in %0d request transactions under mixed stalls",
               docs_sent, items_sent);
      $display("Results: %0d text, %0d token ends, %0d errors, %0d document ends",
               text_count, done_count, error_count, end_count);
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== json_token_lexer.f =====
hdl/jtl_pkg.sv
hdl/jtl_lexer.sv
hdl/json_token_lexer.sv
bench/jtl_checker.sv
bench/tb.sv
